// ----- rtl/script_source_tokenizer_top_assert.svh -----
// Assertion macros for the source tokenizer
`ifndef SCRIPT_SOURCE_TOKENIZER_TOP_ASSERT_SVH
`define SCRIPT_SOURCE_TOKENIZER_TOP_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define SST_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Types and constants shared by the source tokenizer modules.
// ----------------------------------------------------------------------------
package sst_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_NUMBER, M_IDENT, M_AT, M_IVAR, M_OP, M_CR, M_COMMENT,
        M_DQ, M_DQ_ESC, M_DQ_HASH, M_SQ, M_SQ_ESC
    } mode_t;

    localparam logic [6:0] K_EOF      = 7'd36;
    localparam logic [6:0] K_NUMBER   = 7'd41;
    localparam logic [6:0] K_IVAR     = 7'd42;
    localparam logic [6:0] K_IDENT    = 7'd43;
    localparam logic [6:0] K_IDENT_Q  = 7'd44;
    localparam logic [6:0] K_NEWLINE  = 7'd45;
    localparam logic [6:0] K_KW_BASE  = 7'd46;
    localparam logic [6:0] K_ERROR    = 7'd73;
    localparam logic [6:0] K_LBRACE   = 7'd30;
    localparam logic [6:0] K_RBRACE   = 7'd31;
    localparam logic [6:0] K_STR_INT  = 7'd37;
    localparam logic [6:0] K_STR      = 7'd39;

    typedef struct packed {
        logic [6:0] kind;
        logic       is_text;
        logic [7:0] text_byte;
        logic       space_before;
    } res_t;

    // Keywords: letters packed first byte low, length in upper field.
    typedef struct packed {
        logic [2:0]  len;
        logic [47:0] chars;
    } kw_t;

    function automatic kw_t kw_entry(input int idx);
        kw_t k;
        k = '0;
        unique case (idx)
            0:  k = '{3'd2, {32'd0, "fi"}};
            1:  k = '{3'd6, "sselnu"};
            2:  k = '{3'd4, {16'd0, "esle"}};
            3:  k = '{3'd5, {8'd0, "fisle"}};
            4:  k = '{3'd4, {16'd0, "neht"}};
            5:  k = '{3'd4, {16'd0, "nehw"}};
            6:  k = '{3'd4, {16'd0, "esac"}};
            7:  k = '{3'd5, {8'd0, "nigeb"}};
            8:  k = '{3'd6, "erusne"};
            9:  k = '{3'd6, "eucser"};
            10: k = '{3'd5, {8'd0, "ssalc"}};
            11: k = '{3'd6, "eludom"};
            12: k = '{3'd3, {24'd0, "fed"}};
            13: k = '{3'd4, {16'd0, "fles"}};
            14: k = '{3'd2, {32'd0, "od"}};
            15: k = '{3'd5, {8'd0, "dleiy"}};
            16: k = '{3'd6, "nruter"};
            17: k = '{3'd5, {8'd0, "kaerb"}};
            18: k = '{3'd4, {16'd0, "txen"}};
            19: k = '{3'd4, {16'd0, "oder"}};
            20: k = '{3'd4, {16'd0, "eurt"}};
            21: k = '{3'd5, {8'd0, "eslaf"}};
            22: k = '{3'd3, {24'd0, "lin"}};
            23: k = '{3'd3, {24'd0, "ton"}};
            24: k = '{3'd3, {24'd0, "dna"}};
            25: k = '{3'd2, {32'd0, "ro"}};
            default: k = '{3'd3, {24'd0, "dne"}};
        endcase
        return k;
    endfunction

    function automatic logic is_name(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == "_";
    endfunction

endpackage

// ----- rtl/script_source_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// script_source_tokenizer_top
// Streaming tokenizer: one source byte in, up to three results out.
// ----------------------------------------------------------------------------
// A source byte is taken each cycle while the eight-entry result queue has
// room for three more results; each byte is decoded in the cycle it is
// accepted and its results (text bytes first, last flag on the final one)
// drain one per cycle from the queue while m_ready is high. Sustained rate is
// one byte per cycle while m_ready is high and each byte yields at most one
// result; bytes that yield more are limited by the one-result-per-cycle port.
`include "script_source_tokenizer_top_assert.svh"

module script_source_tokenizer_top #(
    parameter int BRACE_DEPTH = 16,
    parameter int LINE_BITS   = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_src_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_kind,
    output logic                 m_is_text,
    output logic [7:0]           m_text_byte,
    output logic                 m_space_before,
    output logic [LINE_BITS-1:0] m_line_number,
    output logic                 m_last
);
    localparam int BW = $clog2(BRACE_DEPTH + 1);
    localparam int SW = $clog2(BRACE_DEPTH);

    logic                 kw_en_reg;
    sst_pkg::mode_t       mode_reg, mode_next;
    logic [6:0]           pop_reg, pop_next;
    logic [7:0]           wb_reg [6];
    logic [2:0]           wl_reg, wl_next;
    logic                 bs_reg [BRACE_DEPTH];
    logic [BW-1:0]        bc_reg, bc_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 sp_reg, sp_next, sc_reg, sc_next;
    logic                 push_ok, push_flag;
    logic                 wb_we;

    sst_pkg::res_t        res [3];
    logic [LINE_BITS-1:0] rline [3];
    logic [1:0]           rn;
    logic                 room, acc;
    logic [7:0]           b;
    logic [6:0]           kwk;
    logic [47:0]          word;
    sst_pkg::res_t        mres;

    assign s_ready = room;
    assign acc     = s_valid && s_ready;
    assign b       = s_src_byte;
    assign word    = {wb_reg[5], wb_reg[4], wb_reg[3], wb_reg[2], wb_reg[1], wb_reg[0]};

    sst_kw_match u_kw (.enabled(kw_en_reg), .word(word), .word_len(wl_reg), .kind(kwk));

    always_comb begin
        logic idle_go, dq_go, sq_go, clr;
        logic [6:0] full;
        mode_next = mode_reg; pop_next = pop_reg; wl_next = wl_reg; bc_next = bc_reg;
        line_next = line_reg; sp_next = sp_reg; sc_next = sc_reg;
        push_ok = 1'b0; push_flag = 1'b0; wb_we = 1'b0;
        rn = '0; idle_go = 1'b0; dq_go = 1'b0; sq_go = 1'b0; clr = 1'b0; full = '0;
        for (int i = 0; i < 3; i++) res[i] = '0;
        // emit helpers are written inline: res[rn] then rn++
        unique case (mode_reg)
            sst_pkg::M_NUMBER: if (!(b >= "0" && b <= "9")) begin
                res[rn] = '{sst_pkg::K_NUMBER, 1'b0, 8'd0, sp_next}; rn++; sp_next = 1'b0;
                idle_go = 1'b1;
            end
            sst_pkg::M_IDENT: if (sst_pkg::is_name(b)) begin
                wb_we = wl_reg < 3'd6;
                if (wl_reg < 3'd7) wl_next = wl_reg + 3'd1;
            end else if (b == "?" || b == "!") begin
                res[rn] = '{sst_pkg::K_IDENT_Q, 1'b0, 8'd0, sp_next}; rn++; sp_next = 1'b0;
                wl_next = '0; mode_next = sst_pkg::M_IDLE;
            end else begin
                res[rn] = '{(wl_reg > 3'd6) ? sst_pkg::K_IDENT : kwk, 1'b0, 8'd0, sp_next};
                rn++; sp_next = 1'b0; wl_next = '0; idle_go = 1'b1;
            end
            sst_pkg::M_AT: if (sst_pkg::is_name(b)) mode_next = sst_pkg::M_IVAR;
            else begin
                res[rn] = '{sst_pkg::K_ERROR, 1'b0, "@", sp_next}; rn++; sp_next = 1'b0;
                idle_go = 1'b1;
            end
            sst_pkg::M_IVAR: if (!sst_pkg::is_name(b)) begin
                res[rn] = '{sst_pkg::K_IVAR, 1'b0, 8'd0, sp_next}; rn++; sp_next = 1'b0;
                idle_go = 1'b1;
            end
            sst_pkg::M_OP: begin
                if (b == "=") begin
                    if (pop_reg >= 7'd1 && pop_reg <= 7'd4) full = pop_reg + 7'd4;
                    else if (pop_reg == 7'd12) full = 7'd13;
                    else if (pop_reg == 7'd35) full = 7'd14;
                    else if (pop_reg == 7'd15) full = 7'd16;
                    else if (pop_reg == 7'd17) full = 7'd18;
                end else if (b == ":" && pop_reg == 7'd22) full = 7'd23;
                else if (b == "|" && pop_reg == 7'd32) full = 7'd34;
                else if (b == "&" && pop_reg == 7'd25) full = 7'd33;
                if (b == "=" && pop_reg == 7'd11) pop_next = 7'd12;
                else begin
                    pop_next = '0;
                    res[rn] = '{(full != 0) ? full : pop_reg, 1'b0, 8'd0, sp_next};
                    rn++; sp_next = 1'b0;
                    if (full != 0) mode_next = sst_pkg::M_IDLE;
                    else idle_go = 1'b1;
                end
            end
            sst_pkg::M_CR: begin
                mode_next = sst_pkg::M_IDLE;
                if (b != 8'd10) idle_go = 1'b1;
            end
            sst_pkg::M_COMMENT: if (b == 8'd10 || b == 8'd13 || b == 8'd0) idle_go = 1'b1;
            sst_pkg::M_DQ: dq_go = 1'b1;
            sst_pkg::M_DQ_ESC: begin
                mode_next = sst_pkg::M_DQ;
                if (b == "n") begin res[rn] = '{7'd0, 1'b1, 8'd10, sp_next}; rn++; end
                else if (b == "r") begin res[rn] = '{7'd0, 1'b1, 8'd13, sp_next}; rn++; end
                else if (b == "\\" || b == "'") begin
                    res[rn] = '{7'd0, 1'b1, b, sp_next}; rn++;
                end else begin
                    res[rn] = '{7'd0, 1'b1, "\\", sp_next}; rn++; dq_go = 1'b1;
                end
            end
            sst_pkg::M_DQ_HASH: if (b == "{") begin
                push_ok = bc_reg < BW'(BRACE_DEPTH); push_flag = 1'b1;
                if (push_ok) bc_next = bc_reg + 1'b1;
                res[rn] = '{sst_pkg::K_STR_INT + {6'd0, sc_reg}, 1'b0, 8'd0, sp_next};
                rn++; sp_next = 1'b0; sc_next = 1'b0; mode_next = sst_pkg::M_IDLE;
                if (!push_ok) begin
                    res[rn] = '{sst_pkg::K_ERROR, 1'b0, "{", sp_next}; rn++;
                end
            end else begin
                res[rn] = '{7'd0, 1'b1, "#", sp_next}; rn++; dq_go = 1'b1;
            end
            sst_pkg::M_SQ: sq_go = 1'b1;
            sst_pkg::M_SQ_ESC: begin
                mode_next = sst_pkg::M_SQ;
                if (b == "\\" || b == "'") begin res[rn] = '{7'd0, 1'b1, b, sp_next}; rn++; end
                else begin res[rn] = '{7'd0, 1'b1, "\\", sp_next}; rn++; sq_go = 1'b1; end
            end
            default: idle_go = 1'b1;
        endcase
        if (dq_go) begin
            mode_next = sst_pkg::M_DQ;
            if (b == 8'd0) clr = 1'b1;
            else if (b == "\"") begin
                res[rn] = '{sst_pkg::K_STR + {6'd0, sc_next}, 1'b0, 8'd0, sp_next};
                rn++; sp_next = 1'b0; sc_next = 1'b0; mode_next = sst_pkg::M_IDLE;
            end else if (b == "\\") mode_next = sst_pkg::M_DQ_ESC;
            else if (b == "#") mode_next = sst_pkg::M_DQ_HASH;
            else begin res[rn] = '{7'd0, 1'b1, b, sp_next}; rn++; end
        end
        if (sq_go) begin
            mode_next = sst_pkg::M_SQ;
            if (b == 8'd0) clr = 1'b1;
            else if (b == "'") begin
                res[rn] = '{sst_pkg::K_STR, 1'b0, 8'd0, sp_next}; rn++; sp_next = 1'b0;
                mode_next = sst_pkg::M_IDLE;
            end else if (b == "\\") mode_next = sst_pkg::M_SQ_ESC;
            else begin res[rn] = '{7'd0, 1'b1, b, sp_next}; rn++; end
        end
        if (idle_go) begin
            mode_next = sst_pkg::M_IDLE;
            if (b == 8'd0) clr = 1'b1;
            else if (b == 8'd10 || b == 8'd13) begin
                line_next = line_reg + 1'b1;
                res[rn] = '{sst_pkg::K_NEWLINE, 1'b0, 8'd0, sp_next}; rn++; sp_next = 1'b0;
                if (b == 8'd13) mode_next = sst_pkg::M_CR;
            end else if (b <= 8'd32) sp_next = 1'b1;
            else if (b >= "0" && b <= "9") mode_next = sst_pkg::M_NUMBER;
            else if (sst_pkg::is_name(b)) begin
                mode_next = sst_pkg::M_IDENT; wl_next = 3'd1; wb_we = 1'b1;
            end else begin
                unique case (b)
                    "@": mode_next = sst_pkg::M_AT;
                    "+": begin mode_next = sst_pkg::M_OP; pop_next = 7'd1; end
                    "-": begin mode_next = sst_pkg::M_OP; pop_next = 7'd2; end
                    "*": begin mode_next = sst_pkg::M_OP; pop_next = 7'd3; end
                    "/": begin mode_next = sst_pkg::M_OP; pop_next = 7'd4; end
                    "=": begin mode_next = sst_pkg::M_OP; pop_next = 7'd11; end
                    "!": begin mode_next = sst_pkg::M_OP; pop_next = 7'd35; end
                    ">": begin mode_next = sst_pkg::M_OP; pop_next = 7'd15; end
                    "<": begin mode_next = sst_pkg::M_OP; pop_next = 7'd17; end
                    ":": begin mode_next = sst_pkg::M_OP; pop_next = 7'd22; end
                    "|": begin mode_next = sst_pkg::M_OP; pop_next = 7'd32; end
                    "&": begin mode_next = sst_pkg::M_OP; pop_next = 7'd25; end
                    "(", ")", "?", ";", ".", ",", "[", "]": begin
                        unique case (b)
                            "(": full = 7'd26;
                            ")": full = 7'd27;
                            "?": full = 7'd19;
                            ";": full = 7'd24;
                            ".": full = 7'd20;
                            ",": full = 7'd21;
                            "[": full = 7'd28;
                            default: full = 7'd29;
                        endcase
                        res[rn] = '{full, 1'b0, 8'd0, sp_next}; rn++; sp_next = 1'b0;
                    end
                    "{": begin
                        push_ok = bc_reg < BW'(BRACE_DEPTH); push_flag = 1'b0;
                        if (push_ok) bc_next = bc_reg + 1'b1;
                        res[rn] = '{sst_pkg::K_LBRACE, 1'b0, 8'd0, sp_next};
                        rn++; sp_next = 1'b0;
                        if (!push_ok) begin
                            res[rn] = '{sst_pkg::K_ERROR, 1'b0, "{", sp_next}; rn++;
                        end
                    end
                    "}": begin
                        if (bc_reg == '0) begin
                            res[rn] = '{sst_pkg::K_RBRACE, 1'b0, 8'd0, sp_next};
                            rn++; sp_next = 1'b0;
                        end else begin
                            bc_next = bc_reg - 1'b1;
                            if (bs_reg[SW'(bc_reg - 1'b1)]) begin
                                mode_next = sst_pkg::M_DQ; sc_next = 1'b1;
                            end else begin
                                res[rn] = '{sst_pkg::K_RBRACE, 1'b0, 8'd0, sp_next};
                                rn++; sp_next = 1'b0;
                            end
                        end
                    end
                    "#": begin mode_next = sst_pkg::M_COMMENT; sp_next = 1'b0; end
                    "\"": begin mode_next = sst_pkg::M_DQ; sc_next = 1'b0; end
                    "'": mode_next = sst_pkg::M_SQ;
                    default: begin
                        res[rn] = '{sst_pkg::K_ERROR, 1'b0, b, sp_next}; rn++; sp_next = 1'b0;
                    end
                endcase
            end
        end
        if (clr) begin
            res[rn] = '{sst_pkg::K_EOF, 1'b0, 8'd0, sp_next}; rn++;
            mode_next = sst_pkg::M_IDLE; pop_next = '0; wl_next = '0; bc_next = '0;
            line_next = '0; sp_next = 1'b0; sc_next = 1'b0;
        end
    end

    // Newline results carry the advanced count, all others the count before it.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rline[i] = (!res[i].is_text && res[i].kind == sst_pkg::K_NEWLINE) ?
                       line_reg + LINE_BITS'(1) : line_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc && wb_we) wb_reg[(mode_reg == sst_pkg::M_IDENT) ? wl_reg : 3'd0] <= b;
        if (acc && push_ok) bs_reg[SW'(bc_reg)] <= push_flag;
        if (!aresetn) begin
            kw_en_reg <= 1'b1;
            mode_reg  <= sst_pkg::M_IDLE;
            pop_reg   <= '0;
            wl_reg    <= '0;
            bc_reg    <= '0;
            line_reg  <= '0;
            sp_reg    <= 1'b0;
            sc_reg    <= 1'b0;
        end else begin
            if (cfg_we) kw_en_reg <= cfg_wdata;
            if (acc) begin
                mode_reg <= mode_next;
                pop_reg  <= pop_next;
                wl_reg   <= wl_next;
                bc_reg   <= bc_next;
                line_reg <= line_next;
                sp_reg   <= sp_next;
                sc_reg   <= sc_next;
            end
        end
    end

    sst_out_fifo #(.LINE_BITS(LINE_BITS)) u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push_n(acc ? rn : 2'd0), .push_res(res),
        .push_line(rline), .room(room), .m_valid(m_valid), .m_ready(m_ready),
        .m_res(mres), .m_line(m_line_number), .m_last(m_last)
    );

    assign m_kind         = mres.kind;
    assign m_is_text      = mres.is_text;
    assign m_text_byte    = mres.text_byte;
    assign m_space_before = mres.space_before;

    `SST_ASSERT_IMP(a_bc_range, aclk, aresetn, 1'b1, bc_reg <= BW'(BRACE_DEPTH),
        "brace count beyond depth")
    `SST_ASSERT_NEXT(a_eof_reset, aclk, aresetn, acc && s_src_byte == 8'd0,
        mode_reg == sst_pkg::M_IDLE && bc_reg == '0, "end of input did not reset")
    `SST_ASSERT_IMP(a_wl_idle, aclk, aresetn, mode_reg != sst_pkg::M_IDENT, wl_reg == '0,
        "word length left outside identifier")
endmodule

// ----- rtl/sst_kw_match.sv -----
// ----------------------------------------------------------------------------
// sst_kw_match
// Parallel keyword compare of the buffered word.
// ----------------------------------------------------------------------------
module sst_kw_match (
    input  logic        enabled,
    input  logic [47:0] word,
    input  logic [2:0]  word_len,
    output logic [6:0]  kind
);
    sst_pkg::kw_t e;
    logic [47:0]  mask;

    always_comb begin
        kind = sst_pkg::K_IDENT;
        e    = '0;
        mask = '0;
        for (int i = 26; i >= 0; i--) begin
            e    = sst_pkg::kw_entry(i);
            mask = 48'hFFFF_FFFF_FFFF >> (6'd8 * (6'd6 - {3'd0, e.len}));
            if (enabled && word_len == e.len && (word & mask) == e.chars)
                kind = sst_pkg::K_KW_BASE + 7'(i);
        end
    end
endmodule

// ----- rtl/sst_out_fifo.sv -----
// ----------------------------------------------------------------------------
// sst_out_fifo
// Result queue: takes up to three results a cycle, emits one while m_ready is high.
// ----------------------------------------------------------------------------
`include "script_source_tokenizer_top_assert.svh"

module sst_out_fifo #(
    parameter int LINE_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           push_n,
    input  sst_pkg::res_t        push_res [3],
    input  logic [LINE_BITS-1:0] push_line [3],
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sst_pkg::res_t        m_res,
    output logic [LINE_BITS-1:0] m_line,
    output logic                 m_last
);
    localparam int DEPTH = 8;

    typedef struct packed {
        sst_pkg::res_t        r;
        logic [LINE_BITS-1:0] line;
        logic                 last;
    } ent_t;

    ent_t       mem_reg [DEPTH];
    logic [2:0] wr_reg, rd_reg;
    logic [3:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop      = m_valid && m_ready;
    assign m_valid  = cnt_reg != 4'd0;
    assign room     = cnt_reg <= 4'd5;
    assign m_res    = mem_reg[rd_reg].r;
    assign m_line   = mem_reg[rd_reg].line;
    assign m_last   = mem_reg[rd_reg].last;
    assign cnt_next = cnt_reg + {2'd0, push_n} - {3'd0, pop};

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < push_n) begin
                mem_reg[wr_reg + 3'(i)] <= '{push_res[i], push_line[i], 2'(i + 1) == push_n};
            end
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_reg + {1'b0, push_n};
            rd_reg  <= rd_reg + {2'd0, pop};
            cnt_reg <= cnt_next;
        end
    end

    `SST_ASSERT_IMP(a_no_overflow, aclk, aresetn, push_n != 2'd0, room,
        "result queue overflow")
    `SST_ASSERT_NEXT(a_cnt_track, aclk, aresetn, 1'b1,
        cnt_reg == $past(cnt_next), "queue count mismatch")
    `SST_ASSERT_IMP(a_cnt_max, aclk, aresetn, 1'b1, cnt_reg <= 4'd8,
        "queue count beyond depth")
endmodule
